### sv/ueb_pkg.sv
package ueb_pkg;

  localparam int NUM_BINS   = 9;
  localparam int COUNT_BITS = 21;

  localparam int BIN_SLOTS  = 16;
  localparam int TRIG_W     = 8;
  localparam int TICK_W     = 21;
  localparam int WIDTH_W    = 11;
  localparam int SPEED_W    = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 21;
  localparam int CMP_W      = (COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE       = 3'd0,
    REG_TRIGGER_TICKS = 3'd1,
    REG_RISE_TIMEOUT = 3'd2,
    REG_HIGH_TIMEOUT = 3'd3,
    REG_HOLD_TICKS   = 3'd4
  } reg_idx_t;

  localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = TRIG_W'(10);
  localparam logic [TICK_W-1:0]  TIMEOUT_RST       = TICK_W'(1000000);
  localparam logic [SPEED_W-1:0] SPEED_RST         = SPEED_W'(5);

  // Upper width limit of each speed level; unused tail repeats the last one.
  localparam logic [WIDTH_W-1:0] BIN_LIMIT [BIN_SLOTS] = '{
    11'd167,  11'd443,  11'd702,  11'd841,  11'd1097, 11'd1306, 11'd1416, 11'd1507,
    11'd1772, 11'd1772, 11'd1772, 11'd1772, 11'd1772, 11'd1772, 11'd1772, 11'd1772
  };

  typedef struct packed {
    logic              enable;
    logic [TRIG_W-1:0] trigger_ticks;
    logic [TICK_W-1:0] rise_timeout;
    logic [TICK_W-1:0] high_timeout;
    logic [TICK_W-1:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic               timed_out;
    logic [SPEED_W-1:0] speed_level;
    logic [WIDTH_W-1:0] echo_width;
    logic               result_valid;
    logic               trig_out;
  } res_t;

endpackage

### sv/ultrasonic_echo_ranger_binner_core.sv
// Channel  | Dir | Handshake         | Payload
// s_*      | in  | s_tvalid/s_tready | s_tdata: one tick, echo level
// m_*      | out | m_tvalid/m_tready | m_tdata: trigger level, result, width, speed
// cfg_*    | in  | cfg_we            | cfg_addr, cfg_wdata: register write
//
// One word in, one word out, every cycle while m_tready is high. A tick is
// held in the input register, then the phase logic and threshold bins fill the
// output register. Back-pressure on m_tready holds the output register and then
// the input register. rst (synchronous) empties both stages, loads register
// defaults and returns the sequencer to idle.
module ultrasonic_echo_ranger_binner_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ueb_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] echo_level
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] trig_out, [1] result_valid, [12:2] echo_width, [16:13] speed_level,
  // [17] timed_out
  output logic [ueb_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_we,
  input  logic [ueb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [ueb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ueb_pkg::cfg_t cfg;
  ueb_pkg::res_t res;
  logic          in_valid;
  logic          echo;
  logic          adv;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  ueb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ueb_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .echo (echo),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      echo <= s_tdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= ueb_pkg::OUT_DATA_W'(res);
    end
  end

endmodule

### sv/ueb_regs.sv
module ueb_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [ueb_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [ueb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output ueb_pkg::cfg_t                    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b1;
      cfg.trigger_ticks <= ueb_pkg::TRIGGER_TICKS_RST;
      cfg.rise_timeout  <= ueb_pkg::TIMEOUT_RST;
      cfg.high_timeout  <= ueb_pkg::TIMEOUT_RST;
      cfg.hold_ticks    <= ueb_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ueb_pkg::REG_ENABLE:        cfg.enable        <= cfg_wdata[0];
        ueb_pkg::REG_TRIGGER_TICKS: cfg.trigger_ticks <= cfg_wdata[ueb_pkg::TRIG_W-1:0];
        ueb_pkg::REG_RISE_TIMEOUT:  cfg.rise_timeout  <= cfg_wdata[ueb_pkg::TICK_W-1:0];
        ueb_pkg::REG_HIGH_TIMEOUT:  cfg.high_timeout  <= cfg_wdata[ueb_pkg::TICK_W-1:0];
        ueb_pkg::REG_HOLD_TICKS:    cfg.hold_ticks    <= cfg_wdata[ueb_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/ueb_bin.sv
module ueb_bin (
  input  logic [ueb_pkg::COUNT_BITS-1:0] width,
  output logic                           over_top,
  output logic [ueb_pkg::SPEED_W-1:0]    level
);

  always_comb begin
    over_top = ueb_pkg::CMP_W'(width) >
               ueb_pkg::CMP_W'(ueb_pkg::BIN_LIMIT[ueb_pkg::NUM_BINS-1]);
    level = '0;
    // Scan from the top so the lowest matching threshold wins.
    for (int i = ueb_pkg::NUM_BINS - 1; i >= 0; i--) begin
      if (ueb_pkg::CMP_W'(width) <= ueb_pkg::CMP_W'(ueb_pkg::BIN_LIMIT[i])) begin
        level = ueb_pkg::SPEED_W'(i + 1);
      end
    end
  end

endmodule

### sv/ueb_ctrl.sv
module ueb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          echo,
  input  ueb_pkg::cfg_t cfg,
  output ueb_pkg::res_t res
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_RISE = 3'd2,
    PH_MEAS = 3'd3,
    PH_HOLD = 3'd4
  } phase_t;

  localparam logic [ueb_pkg::COUNT_BITS-1:0] CNT_MAX = '1;

  phase_t                          phase, phase_a, phase_next;
  logic [ueb_pkg::COUNT_BITS-1:0]  phase_cnt, pc_a, phase_cnt_next;
  logic [ueb_pkg::COUNT_BITS-1:0]  width_cnt, wc_a, width_cnt_next;
  logic [ueb_pkg::COUNT_BITS-1:0]  pc_inc;
  logic [ueb_pkg::SPEED_W-1:0]     speed, speed_next;
  logic                            trig, done, tmo_a;
  logic                            over_top;
  logic [ueb_pkg::SPEED_W-1:0]     level;

  function automatic logic [ueb_pkg::COUNT_BITS-1:0] sat_inc(
    input logic [ueb_pkg::COUNT_BITS-1:0] v
  );
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // Phase advance and counting; done marks the end of a measurement.
  always_comb begin
    phase_a = phase;
    pc_a    = phase_cnt;
    wc_a    = width_cnt;
    pc_inc  = '0;
    trig    = 1'b0;
    done    = 1'b0;
    tmo_a   = 1'b0;
    if (!cfg.enable) begin
      phase_a = PH_IDLE;
      pc_a    = '0;
      wc_a    = '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          phase_a = PH_TRIG;
          pc_a    = '0;
        end
        PH_HOLD: begin
          if (ueb_pkg::CMP_W'(phase_cnt) >= ueb_pkg::CMP_W'(cfg.hold_ticks)) begin
            phase_a = PH_TRIG;
            pc_a    = '0;
          end else begin
            pc_a = sat_inc(phase_cnt);
          end
        end
        PH_RISE: begin
          if (echo) begin
            phase_a = PH_MEAS;
            wc_a    = '0;
          end else begin
            pc_inc = sat_inc(phase_cnt);
            pc_a   = pc_inc;
            if (ueb_pkg::CMP_W'(pc_inc) >= ueb_pkg::CMP_W'(cfg.rise_timeout)) begin
              phase_a = PH_MEAS;
              wc_a    = '0;
              pc_a    = '0;
            end
          end
        end
        PH_MEAS: ;
        PH_TRIG: ;
        default: begin
          phase_a = PH_TRIG;
          pc_a    = '0;
        end
      endcase

      if (phase_a == PH_TRIG) begin
        trig = 1'b1;
        pc_a = sat_inc(pc_a);
        if (ueb_pkg::CMP_W'(pc_a) >= ueb_pkg::CMP_W'(cfg.trigger_ticks)) begin
          phase_a = PH_RISE;
          pc_a    = '0;
        end
      end else if (phase_a == PH_MEAS &&
                   (echo || wc_a != '0 || pc_a == '0)) begin
        if (echo) begin
          wc_a = sat_inc(wc_a);
          if (ueb_pkg::CMP_W'(wc_a) >= ueb_pkg::CMP_W'(cfg.high_timeout)) begin
            done  = 1'b1;
            tmo_a = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
    end
  end

  ueb_bin u_bin (
    .width    (wc_a),
    .over_top (over_top),
    .level    (level)
  );

  // Close out a measurement: oversized widths retrigger without a result.
  always_comb begin
    phase_next       = phase_a;
    phase_cnt_next   = pc_a;
    width_cnt_next   = wc_a;
    speed_next       = speed;
    res.trig_out     = trig;
    res.result_valid = 1'b0;
    res.echo_width   = '0;
    res.timed_out    = 1'b0;
    if (done) begin
      width_cnt_next = '0;
      phase_cnt_next = '0;
      if (over_top) begin
        phase_next = PH_TRIG;
      end else begin
        speed_next       = level;
        res.result_valid = 1'b1;
        res.echo_width   = wc_a[ueb_pkg::WIDTH_W-1:0];
        res.timed_out    = tmo_a;
        phase_next       = PH_HOLD;
      end
    end
    res.speed_level = speed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      phase_cnt <= '0;
      width_cnt <= '0;
      speed     <= ueb_pkg::SPEED_RST;
    end else if (adv) begin
      phase     <= phase_next;
      phase_cnt <= phase_cnt_next;
      width_cnt <= width_cnt_next;
      speed     <= speed_next;
    end
  end

endmodule

### sv/ueb_checker.sv
module ueb_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [ueb_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [ueb_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           cfg_we,
  input logic [ueb_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [ueb_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // A result never lands on a trigger tick.
  a_no_trig_with_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> !m_tdata[0])
    else $error("trigger high on a result word");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[1] |-> m_tdata[12:2] == '0 && !m_tdata[17])
    else $error("width or timeout set without a result");

  a_width_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |->
      m_tdata[12:2] <= ueb_pkg::BIN_LIMIT[ueb_pkg::NUM_BINS-1])
    else $error("reported width above top threshold");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // An empty output register never stalls the input.
  a_ready_after_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

endmodule

bind ultrasonic_echo_ranger_binner_core ueb_checker u_chk (.*);

### test/tb_ultrasonic_echo_ranger_binner_core.sv
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_binner_core;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_TICKS  = 900;
  localparam int SETTLE_CYCLES = 4;
  localparam int CEIL_IDX      = (ueb_pkg::NUM_BINS - 1) & (ueb_pkg::BIN_SLOTS - 1);

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_TRIGGER,
    SEQ_WAIT_ECHO,
    SEQ_MEASURE,
    SEQ_HOLD
  } seq_t;

  typedef struct {
    bit            setup_row;
    ueb_pkg::cfg_t setup;
    logic          echo;
    bit            typed;
    ueb_pkg::res_t want;
  } script_row_t;

  localparam ueb_pkg::cfg_t RESET_SETUP = '{
    enable:        1'b1,
    trigger_ticks: ueb_pkg::TRIGGER_TICKS_RST,
    rise_timeout:  ueb_pkg::TIMEOUT_RST,
    high_timeout:  ueb_pkg::TIMEOUT_RST,
    hold_ticks:    ueb_pkg::TIMEOUT_RST
  };

  // speed level n covers widths up to SPEED_EDGE[n-1]
  localparam int SPEED_EDGE [ueb_pkg::BIN_SLOTS] = '{
    167, 443, 702, 841, 1097, 1306, 1416, 1507,
    1772, 1772, 1772, 1772, 1772, 1772, 1772, 1772
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ueb_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [ueb_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we;
  logic [ueb_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [ueb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  bit quiet_run = 1'b0;
  int mismatches = 0;
  int cycles = 0;

  // predicted sequencer state
  ueb_pkg::cfg_t                  ranger_cfg;
  seq_t                           ranger_seq;
  logic [ueb_pkg::COUNT_BITS-1:0] ranger_phase_cnt;
  logic [ueb_pkg::COUNT_BITS-1:0] ranger_width_cnt;
  logic [ueb_pkg::SPEED_W-1:0]    ranger_speed;

  ueb_pkg::res_t ranger_out_q [$];
  script_row_t   script [$];
  int            wide_widths [$];

  ultrasonic_echo_ranger_binner_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [ueb_pkg::COUNT_BITS-1:0] sat_inc(
    input logic [ueb_pkg::COUNT_BITS-1:0] v
  );
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic ueb_pkg::res_t mk_res(input int trig, input int valid, input int width,
                                           input int speed, input int tmo);
    ueb_pkg::res_t r;
    r.trig_out     = 1'(trig);
    r.result_valid = 1'(valid);
    r.echo_width   = ueb_pkg::WIDTH_W'(width);
    r.speed_level  = ueb_pkg::SPEED_W'(speed);
    r.timed_out    = 1'(tmo);
    return r;
  endfunction

  // One tick of the ranger: advances the predicted state, returns the output word.
  function automatic ueb_pkg::res_t ranger_tick(input logic echo);
    ueb_pkg::res_t                  r;
    logic                           done;
    logic [ueb_pkg::COUNT_BITS-1:0] w;
    r    = '0;
    done = 1'b0;
    if (!ranger_cfg.enable) begin
      ranger_seq       = SEQ_IDLE;
      ranger_phase_cnt = '0;
      ranger_width_cnt = '0;
    end else begin
      case (ranger_seq)
        SEQ_IDLE: begin
          ranger_seq       = SEQ_TRIGGER;
          ranger_phase_cnt = '0;
        end
        SEQ_HOLD: begin
          if (ranger_phase_cnt >= ranger_cfg.hold_ticks) begin
            ranger_seq       = SEQ_TRIGGER;
            ranger_phase_cnt = '0;
          end else begin
            ranger_phase_cnt = sat_inc(ranger_phase_cnt);
          end
        end
        SEQ_WAIT_ECHO: begin
          if (echo) begin
            // phase count kept: it only matters when measuring after a timeout
            ranger_seq       = SEQ_MEASURE;
            ranger_width_cnt = '0;
          end else begin
            ranger_phase_cnt = sat_inc(ranger_phase_cnt);
            if (ranger_phase_cnt >= ranger_cfg.rise_timeout) begin
              ranger_seq       = SEQ_MEASURE;
              ranger_width_cnt = '0;
              ranger_phase_cnt = '0;
            end
          end
        end
        SEQ_TRIGGER, SEQ_MEASURE: ;
        default: begin
          ranger_seq       = SEQ_TRIGGER;
          ranger_phase_cnt = '0;
        end
      endcase

      if (ranger_seq == SEQ_TRIGGER) begin
        r.trig_out       = 1'b1;
        ranger_phase_cnt = sat_inc(ranger_phase_cnt);
        if (ranger_phase_cnt >= ranger_cfg.trigger_ticks) begin
          ranger_seq       = SEQ_WAIT_ECHO;
          ranger_phase_cnt = '0;
        end
      end else if (ranger_seq == SEQ_MEASURE &&
                   (echo || ranger_width_cnt != '0 || ranger_phase_cnt == '0)) begin
        if (echo) begin
          ranger_width_cnt = sat_inc(ranger_width_cnt);
          if (ranger_width_cnt >= ranger_cfg.high_timeout) begin
            done        = 1'b1;
            r.timed_out = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end

      if (done) begin
        w                = ranger_width_cnt;
        ranger_width_cnt = '0;
        ranger_phase_cnt = '0;
        if (w > SPEED_EDGE[CEIL_IDX]) begin
          // too wide: dropped, retrigger next tick
          ranger_seq  = SEQ_TRIGGER;
          r.timed_out = 1'b0;
        end else begin
          for (int i = ueb_pkg::NUM_BINS - 1; i >= 0; i--) begin
            if (i < ueb_pkg::BIN_SLOTS && w <= SPEED_EDGE[i])
              ranger_speed = ueb_pkg::SPEED_W'(i + 1);
          end
          r.result_valid = 1'b1;
          r.echo_width   = w[ueb_pkg::WIDTH_W-1:0];
          ranger_seq     = SEQ_HOLD;
        end
      end
    end
    r.speed_level = ranger_speed;
    if (!r.result_valid) r.timed_out = 1'b0;
    return r;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [ueb_pkg::TICK_W-1:0] draw_len(input int lo, input int hi);
    int r;
    r = $urandom_range(99);
    if (r < 10) return '1;
    if (r < 20) return '0;
    return ueb_pkg::TICK_W'($urandom_range(hi, lo));
  endfunction

  function automatic void add_setup(input ueb_pkg::cfg_t c);
    script_row_t row;
    row           = '{default: '0};
    row.setup_row = 1'b1;
    row.setup     = c;
    script.push_back(row);
  endfunction

  function automatic void add_tick(input logic echo, input bit typed,
                                   input ueb_pkg::res_t want);
    script_row_t row;
    row       = '{default: '0};
    row.echo  = echo;
    row.typed = typed;
    row.want  = want;
    script.push_back(row);
  endfunction

  // Called at a falling edge; returns at a falling edge with tvalid still high.
  task automatic send_tick(input logic echo, input bit typed, input ueb_pkg::res_t want);
    ueb_pkg::res_t predicted;
    while (!quiet_run && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ueb_pkg::IN_DATA_W'(echo);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = ranger_tick(echo);
    ranger_out_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (ranger_out_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_setup(input ueb_pkg::cfg_t c);
    ueb_pkg::reg_idx_t              idx;
    logic [ueb_pkg::CFG_DATA_W-1:0] val;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        ueb_pkg::REG_ENABLE:        val = ueb_pkg::CFG_DATA_W'(c.enable);
        ueb_pkg::REG_TRIGGER_TICKS: val = ueb_pkg::CFG_DATA_W'(c.trigger_ticks);
        ueb_pkg::REG_RISE_TIMEOUT:  val = c.rise_timeout;
        ueb_pkg::REG_HIGH_TIMEOUT:  val = c.high_timeout;
        ueb_pkg::REG_HOLD_TICKS:    val = c.hold_ticks;
        default:                    val = '0;
      endcase
      cfg_we    <= 1'b1;
      cfg_addr  <= idx;
      cfg_wdata <= val;
      @(negedge clk);
      idx = idx.next();
    end
    cfg_we     <= 1'b0;
    ranger_cfg = c;
  endtask

  // Echo source: answers each trigger with a delayed pulse of chosen width.
  task automatic run_ticks(input int count, input bit wide);
    int   delay_left;
    int   high_left;
    int   rise_lim;
    int   r;
    seq_t last_seq;
    logic echo;
    delay_left = 0;
    high_left  = 0;
    last_seq   = SEQ_IDLE;
    for (int t = 0; t < count; t++) begin
      if (ranger_seq == SEQ_WAIT_ECHO && last_seq != SEQ_WAIT_ECHO) begin
        if (wide) begin
          delay_left = $urandom_range(8);
          high_left  = (wide_widths.size() != 0) ? wide_widths.pop_front() : 0;
        end else begin
          rise_lim = int'(ranger_cfg.rise_timeout) + 4;
          if (rise_lim > 60) rise_lim = 60;
          delay_left = $urandom_range(rise_lim);
          r = $urandom_range(99);
          if (r < 70)      high_left = $urandom_range(40);
          else if (r < 85) high_left = $urandom_range(170, 164);
          else             high_left = $urandom_range(300);
        end
      end
      last_seq = ranger_seq;
      if (ranger_seq == SEQ_WAIT_ECHO || ranger_seq == SEQ_MEASURE) begin
        if (delay_left > 0) begin
          echo = 1'b0;
          delay_left--;
        end else if (high_left > 0) begin
          echo = 1'b1;
          high_left--;
        end else begin
          echo = 1'b0;
        end
      end else begin
        echo = 1'($urandom_range(1));
      end
      // glitches break up pulses now and then
      if (!wide && $urandom_range(99) < 8) echo = ~echo;
      send_tick(echo, 1'b0, '0);
    end
  endtask

  task automatic run_wide(input ueb_pkg::cfg_t c);
    int budget;
    budget = 0;
    foreach (wide_widths[i]) budget += wide_widths[i] + 40;
    settle();
    apply_setup(c);
    run_ticks(budget, 1'b1);
  endtask

  always @(negedge clk) m_tready <= quiet_run || ($urandom_range(99) >= 18);

  always @(posedge clk) begin
    ueb_pkg::res_t want;
    ueb_pkg::res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = ueb_pkg::res_t'(m_tdata[$bits(ueb_pkg::res_t)-1:0]);
      if (ranger_out_q.size() == 0) begin
        $display("%0t: word with nothing expected: expected none got %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = ranger_out_q.pop_front();
        check_field("trig_out", 32'(want.trig_out), 32'(got.trig_out));
        check_field("result_valid", 32'(want.result_valid), 32'(got.result_valid));
        check_field("echo_width", 32'(want.echo_width), 32'(got.echo_width));
        check_field("speed_level", 32'(want.speed_level), 32'(got.speed_level));
        check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
        check_field("pad bits", 32'd0,
                    32'(m_tdata[ueb_pkg::OUT_DATA_W-1:$bits(ueb_pkg::res_t)]));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words outstanding", $time, ranger_out_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    script_row_t   row;
    ueb_pkg::cfg_t c;
    int            n;
    int            sent;
    logic [14:0]   echo_walk;

    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= ueb_pkg::REG_ENABLE;
    cfg_wdata <= '0;

    ranger_cfg       = RESET_SETUP;
    ranger_seq       = SEQ_IDLE;
    ranger_phase_cnt = '0;
    ranger_width_cnt = '0;
    ranger_speed     = ueb_pkg::SPEED_RST;

    // out of reset: trigger pulse starts, echo ignored
    add_tick(1'b0, 1'b1, mk_res(1, 0, 0, int'(ueb_pkg::SPEED_RST), 0));
    add_tick(1'b1, 1'b1, mk_res(1, 0, 0, int'(ueb_pkg::SPEED_RST), 0));
    // disable mid-trigger
    c = RESET_SETUP;
    c.enable = 1'b0;
    add_setup(c);
    add_tick(1'b1, 1'b1, mk_res(0, 0, 0, int'(ueb_pkg::SPEED_RST), 0));
    // every length zero
    c = '0;
    c.enable = 1'b1;
    add_setup(c);
    add_tick(1'b0, 1'b1, mk_res(1, 0, 0, int'(ueb_pkg::SPEED_RST), 0));
    add_tick(1'b0, 1'b1, mk_res(0, 1, 0, 1, 0));
    add_tick(1'b0, 1'b1, mk_res(1, 0, 0, 1, 0));
    add_tick(1'b1, 1'b1, mk_res(0, 1, 1, 1, 1));
    // short cycle with a rise timeout, then a four tick echo
    c.trigger_ticks = 8'd2;
    c.rise_timeout  = 21'd3;
    c.high_timeout  = '1;
    c.hold_ticks    = 21'd1;
    add_setup(c);
    echo_walk = 15'b001000000111100;
    for (int i = 14; i >= 0; i--) add_tick(echo_walk[i], 1'b0, '0);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      row = script[i];
      if (row.setup_row) begin
        settle();
        apply_setup(row.setup);
      end else begin
        send_tick(row.echo, row.typed, row.want);
      end
    end

    sent = 0;
    for (int p = 0; sent < RANDOM_TICKS; p++) begin
      c.enable        = ($urandom_range(99) < 90);
      c.trigger_ticks = ueb_pkg::TRIG_W'(draw_len(1, 12));
      c.rise_timeout  = draw_len(1, 60);
      c.high_timeout  = draw_len(1, 250);
      c.hold_ticks    = draw_len(1, 20);
      n = $urandom_range(120, 40);
      case (p)
        0: begin
          c.enable        = 1'b1;
          c.trigger_ticks = '1;
          c.high_timeout  = '1;
          n               = 360;
        end
        1: begin
          c.enable       = 1'b1;
          c.rise_timeout = '1;
          c.hold_ticks   = '1;
        end
        2: c.enable = 1'b0;
        default: ;
      endcase
      settle();
      apply_setup(c);
      quiet_run = (p == 4);
      if (quiet_run) n = 200;
      run_ticks(n, 1'b0);
      sent += n;
    end
    quiet_run = 1'b0;

    // long echo: one just past the second bin edge
    wide_widths = '{444};
    run_wide(ueb_pkg::cfg_t'{1'b1, 8'd1, 21'h1FFFFF, 21'h1FFFFF, 21'd0});

    settle();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
sv/ueb_pkg.sv
sv/ueb_regs.sv
sv/ueb_bin.sv
sv/ueb_ctrl.sv
sv/ultrasonic_echo_ranger_binner_core.sv
sv/ueb_checker.sv
test/tb_ultrasonic_echo_ranger_binner_core.sv
